@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the fraction reduce RTL.
// The enclosing module must have aclk and an active-low aresetn.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define FR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check that a condition implies another in the same cycle
`define FR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ src/fr_pkg.sv @@
// ----------------------------------------------------------------------------
// fr_pkg
// Shared types for the fraction reduce block.
// ----------------------------------------------------------------------------
package fr_pkg;

    // Status of the reduction core as seen by the output stage
    typedef struct packed {
        logic idle;       // ready for a new word
        logic res_valid;  // reduced fraction waiting to be taken
    } fr_status_t;

endpackage

@@ src/fr_sub.sv @@
// ----------------------------------------------------------------------------
// fr_sub
// Shared subtract/compare unit: difference of two unsigned operands plus
// a borrow flag that doubles as the "x is less than y" compare.
// ----------------------------------------------------------------------------
module fr_sub #(
    parameter int WIDTH = 33
) (
    input  logic [WIDTH-1:0] x,
    input  logic [WIDTH-1:0] y,
    output logic [WIDTH-1:0] diff,
    output logic             borrow
);

    logic [WIDTH:0] full;

    // Extend by one bit so the top bit of the result is the borrow
    assign full   = {1'b0, x} - {1'b0, y};
    assign diff   = full[WIDTH-1:0];
    assign borrow = full[WIDTH];

endmodule

@@ src/fr_core.sv @@
// ----------------------------------------------------------------------------
// fr_core
// Sequencer and datapath of the fraction reduce block. Finds the gcd of the
// magnitudes by the binary method, then divides both (with the common power
// of two already removed) by the odd part of the gcd with a restoring divider.
// The gcd and division steps share one fr_sub instance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fr_core #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic [DATA_WIDTH-1:0] num_in,
    input  logic [DATA_WIDTH-1:0] den_in,
    input  logic                  take,
    output fr_pkg::fr_status_t    status,
    output logic [DATA_WIDTH-1:0] num_res,
    output logic [DATA_WIDTH-2:0] den_res,
    output logic                  zero_den
);

    import fr_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int CNT_W = $clog2(DATA_WIDTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TWOS = 3'd1;
    localparam logic [2:0] ST_GCD  = 3'd2;
    localparam logic [2:0] ST_DIVN = 3'd3;
    localparam logic [2:0] ST_DIVD = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

    logic [2:0]       state_reg, state_next;
    logic [W-1:0]     a_reg, a_next;
    logic [W-1:0]     b_reg, b_next;
    logic [W-1:0]     n1_reg, n1_next;
    logic [W-1:0]     d1_reg, d1_next;
    logic [W-1:0]     q_reg, q_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [W-1:0]     nres_reg, nres_next;
    logic [W-2:0]     dres_reg, dres_next;
    logic             flag_reg, flag_next;

    logic [W:0]   sub_x, sub_y, sub_diff;
    logic         sub_borrow;
    logic [W:0]   div_t;
    logic [W-1:0] q_shift;
    logic [W-1:0] nmag, dmag;
    logic         nneg, dneg;
    logic         dividing;

    // Operand select for the shared unit
    assign dividing = (state_reg == ST_DIVN) || (state_reg == ST_DIVD);
    assign div_t    = {rem_reg, q_reg[W-1]};
    assign sub_x    = dividing ? div_t : {1'b0, a_reg};
    assign sub_y    = dividing ? {1'b0, a_reg} : {1'b0, b_reg};

    fr_sub #(.WIDTH(W + 1)) u_sub (
        .x      (sub_x),
        .y      (sub_y),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    // One restoring-division step: shift quotient, insert new bit
    assign q_shift = {q_reg[W-2:0], ~sub_borrow};

    // Input magnitudes and signs
    assign nneg = num_in[W-1];
    assign dneg = den_in[W-1];
    assign nmag = nneg ? ({W{1'b0}} - num_in) : num_in;
    assign dmag = dneg ? ({W{1'b0}} - den_in) : den_in;

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        n1_next    = n1_reg;
        d1_next    = d1_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        nres_next  = nres_reg;
        dres_next  = dres_reg;
        flag_next  = flag_reg;
        case (state_reg)
            ST_IDLE: begin
                // Take a word; settle zero cases at once
                if (in_valid) begin
                    neg_next = nneg ^ dneg;
                    if (den_in == '0) begin
                        flag_next  = 1'b1;
                        dres_next  = '0;
                        if (num_in == '0) begin
                            nres_next = '0;
                        end else if (nneg) begin
                            nres_next = '1;
                        end else begin
                            nres_next = W'(1);
                        end
                        state_next = ST_DONE;
                    end else if (num_in == '0) begin
                        flag_next  = 1'b0;
                        nres_next  = '0;
                        dres_next  = (W-1)'(1);
                        state_next = ST_DONE;
                    end else begin
                        flag_next  = 1'b0;
                        a_next     = nmag;
                        b_next     = dmag;
                        state_next = ST_TWOS;
                    end
                end
            end
            ST_TWOS: begin
                // Drop common factors of two, keep the shifted operands
                if (!a_reg[0] && !b_reg[0]) begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                end else begin
                    n1_next    = a_reg;
                    d1_next    = b_reg;
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                // Binary gcd step; a holds the odd gcd when b reaches zero
                if (b_reg == '0) begin
                    q_next     = n1_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVN;
                end else if (!a_reg[0]) begin
                    a_next = a_reg >> 1;
                end else if (!b_reg[0]) begin
                    b_next = b_reg >> 1;
                end else if (!sub_borrow) begin
                    a_next = b_reg;
                    b_next = sub_diff[W-1:0];
                end else begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
            end
            ST_DIVN, ST_DIVD: begin
                // Restoring division by a, one quotient bit per cycle
                rem_next = sub_borrow ? div_t[W-1:0] : sub_diff[W-1:0];
                q_next   = q_shift;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    cnt_next = '0;
                    rem_next = '0;
                    if (state_reg == ST_DIVN) begin
                        n1_next    = q_shift;
                        q_next     = d1_reg;
                        state_next = ST_DIVD;
                    end else begin
                        d1_next    = q_shift;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                // Apply sign and saturate to the positive range
                dres_next = d1_reg[W-1] ? '1 : d1_reg[W-2:0];
                if (neg_reg) begin
                    nres_next = {W{1'b0}} - n1_reg;
                end else if (n1_reg[W-1]) begin
                    nres_next = {1'b0, {(W-1){1'b1}}};
                end else begin
                    nres_next = n1_reg;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold the result until the output stage takes it
                if (take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        n1_reg   <= n1_next;
        d1_reg   <= d1_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        nres_reg <= nres_next;
        dres_reg <= dres_next;
        flag_reg <= flag_next;
    end

    assign status.idle      = (state_reg == ST_IDLE);
    assign status.res_valid = (state_reg == ST_DONE);
    assign num_res          = nres_reg;
    assign den_res          = dres_reg;
    assign zero_den         = flag_reg;

    // The gcd candidate in a never collapses to zero
    `FR_ASSERT_IMPL(a_gcd_nonzero, state_reg == ST_TWOS || state_reg == ST_GCD, a_reg != '0, "gcd operand a is zero")
    // Partial remainder stays below the divisor
    `FR_ASSERT_IMPL(a_rem_below, dividing, rem_reg < a_reg, "remainder not below divisor")
    // A taken result frees the core for the next word
    `FR_ASSERT(a_take_idle, (take && state_reg == ST_DONE) |=> state_reg == ST_IDLE, "core not idle after result taken")

endmodule

@@ src/fraction_reduce_unit.sv @@
// ----------------------------------------------------------------------------
// fraction_reduce_unit
// Brings a signed fraction to lowest terms with a positive denominator.
// ----------------------------------------------------------------------------
// Each input word carries a numerator and a denominator; the unit returns the
// fraction divided by the gcd of their magnitudes, sign on the numerator.
// 0/d gives 0/1; n/0 gives +1/0 or -1/0 and 0/0 gives 0/0, both with
// zero_denominator set. Zero cases go straight to the result. Otherwise the
// core strips common factors of two, runs the binary gcd, then two
// bit-serial divisions of DATA_WIDTH quotient bits each, numerator first;
// the gcd and both divisions go through the single shared subtractor.
// s_tready is high only while the core is idle; a finished result sits in
// the output register so the next word can be taken while it waits.
// ----------------------------------------------------------------------------
module fraction_reduce_unit #(
    parameter int DATA_WIDTH = 32,
    localparam int S_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W = ((2 * DATA_WIDTH - 1 + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // numerator_in, denominator_in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // numerator_out, denominator_out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    // zero_denominator
    output logic                 m_tuser
);

    import fr_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int M_PAD = M_TDATA_W - (2 * W - 1);

    fr_status_t    status;
    logic          take;
    logic [W-1:0]  num_res;
    logic [W-2:0]  den_res;
    logic          zero_den;

    logic          m_valid_reg, m_valid_next;
    logic [W-1:0]  num_o_reg;
    logic [W-2:0]  den_o_reg;
    logic          zd_o_reg;

    fr_core #(.DATA_WIDTH(W)) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .num_in   (s_tdata[W-1:0]),
        .den_in   (s_tdata[2*W-1:W]),
        .take     (take),
        .status   (status),
        .num_res  (num_res),
        .den_res  (den_res),
        .zero_den (zero_den)
    );

    assign s_tready = status.idle;

    // Load the output register when it is empty or being drained
    assign take = status.res_valid && (!m_valid_reg || m_tready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            num_o_reg <= num_res;
            den_o_reg <= den_res;
            zd_o_reg  <= zero_den;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD{1'b0}}, den_o_reg, num_o_reg};
    assign m_tuser  = zd_o_reg;

endmodule
